// ----- rtl/core/msds_pkg.sv -----
// ----------------------------------------------------------------------------
// msds_pkg
// Shared widths, codes, types and helpers of the mixed derivative stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msds_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int DERIV_W    = 18;
  localparam int SUM_W      = 18;   // four-point sum, signed
  localparam int MAG_W      = 17;   // magnitude of the sum
  localparam int STEP_W     = 5;
  localparam int DIM_W      = 7;
  localparam int POS_W      = 6;
  localparam int COORD_W    = 7;    // stencil coordinate, pos + step
  localparam int LIM_W      = COORD_W + 1;
  localparam int SPAN_W     = 6;    // up to 2 * step
  localparam int DIVISOR_W  = 12;   // span_r * span_c
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // default sizes
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_STEP = 16;
  localparam int MIN_DIM      = 3;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // divider: quotient bits per cycle, step count and widths
  localparam int DIV_BPC   = 5;
  localparam int DIV_STEPS = (MAG_W + DIV_BPC - 1) / DIV_BPC;
  localparam int DIV_W     = DIV_STEPS * DIV_BPC;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RST = 5'd1;
  localparam logic [DIM_W-1:0]  ROWS_RST = 7'd64;
  localparam logic [DIM_W-1:0]  COLS_RST = 7'd64;

  // item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [SPAN_W-1:0]  span;
  } axis_t;

  typedef struct packed {
    logic                    valid;
    logic                    bad;
    logic signed [SUM_W-1:0] sum;
    logic [DIVISOR_W-1:0]    divisor;
  } job_t;

  typedef struct packed {
    logic                      valid;
    logic signed [DERIV_W-1:0] derivative;
    logic                      bad_query;
  } res_t;

  // read order of the four stencil points (row, col)
  typedef enum logic [3:0] {
    RP_HH = 4'b0001,
    RP_LL = 4'b0010,
    RP_LH = 4'b0100,
    RP_HL = 4'b1000
  } rphase_t;

  // forward near the low edge, backward near the high edge, else central
  function automatic axis_t axis_points(input logic [POS_W-1:0]  pos,
                                        input logic [DIM_W-1:0]  len,
                                        input logic [STEP_W-1:0] s);
    axis_t             a;
    logic [LIM_W-1:0]  hi_lim;
    hi_lim = LIM_W'(len) - LIM_W'(s);
    if (COORD_W'(pos) < COORD_W'(s)) begin
      a.lo   = COORD_W'(pos);
      a.hi   = COORD_W'(pos) + COORD_W'(s);
      a.span = SPAN_W'(s);
    end else if (LIM_W'(pos) >= hi_lim) begin
      a.lo   = COORD_W'(pos) - COORD_W'(s);
      a.hi   = COORD_W'(pos);
      a.span = SPAN_W'(s);
    end else begin
      a.lo   = COORD_W'(pos) - COORD_W'(s);
      a.hi   = COORD_W'(pos) + COORD_W'(s);
      a.span = {s, 1'b0};
    end
    return a;
  endfunction

endpackage

// ----- rtl/core/msds_frame_mem.sv -----
// ----------------------------------------------------------------------------
// msds_frame_mem
// Frame sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msds_frame_mem #(
  parameter int DEPTH = msds_pkg::DEF_MAX_ROWS * msds_pkg::DEF_MAX_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [msds_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [msds_pkg::SAMPLE_W-1:0] rdata_r
);

  logic [msds_pkg::SAMPLE_W-1:0] mem_r [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/core/msds_fetch.sv -----
// ----------------------------------------------------------------------------
// msds_fetch
// Query setup, four-read sequencer and signed accumulation of the stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msds_fetch #(
  parameter int MAX_ROWS = msds_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = msds_pkg::DEF_MAX_COLS,
  parameter int MAX_STEP = msds_pkg::DEF_MAX_STEP,
  parameter int AW       = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  msds_pkg::cfg_t                       cfg,
  input  logic                                 start,
  input  logic [msds_pkg::POS_W-1:0]           row,
  input  logic [msds_pkg::POS_W-1:0]           col,
  input  logic signed [msds_pkg::SAMPLE_W-1:0] rd_data,
  output logic                                 hold,
  output logic                                 mem_re,
  output logic [AW-1:0]                        mem_raddr,
  output msds_pkg::job_t                       job_r
);

  msds_pkg::axis_t   ax_row, ax_col;
  logic              bad_now;

  logic              busy_r;
  msds_pkg::rphase_t ph_r, ph_nxt;
  logic [msds_pkg::COORD_W-1:0] rlo_r, rhi_r, clo_r, chi_r;
  logic [msds_pkg::SPAN_W-1:0]  rspan_r, cspan_r;
  logic                         qbad_r;
  logic [msds_pkg::COORD_W-1:0] rsel, csel;

  logic              tag_v_r;
  msds_pkg::rphase_t tag_ph_r;
  logic              tag_bad_r;
  logic [msds_pkg::SPAN_W-1:0]  tag_rspan_r, tag_cspan_r;

  logic signed [msds_pkg::SUM_W-1:0] acc_r, smp, acc_add, acc_sum;

  assign ax_row = msds_pkg::axis_points(row, cfg.rows, cfg.step);
  assign ax_col = msds_pkg::axis_points(col, cfg.cols, cfg.step);

  assign bad_now = (cfg.step == '0) || (int'(cfg.step) > MAX_STEP)
                || (cfg.rows < msds_pkg::DIM_W'(msds_pkg::MIN_DIM))
                || (int'(cfg.rows) > MAX_ROWS)
                || (cfg.cols < msds_pkg::DIM_W'(msds_pkg::MIN_DIM))
                || (int'(cfg.cols) > MAX_COLS)
                || ({1'b0, cfg.step, 1'b0} > cfg.rows)
                || ({1'b0, cfg.step, 1'b0} > cfg.cols)
                || ({1'b0, row} >= cfg.rows)
                || ({1'b0, col} >= cfg.cols);

  // next item may enter on the edge that issues the last read
  assign hold   = busy_r && (ph_r != msds_pkg::RP_HL);
  assign mem_re = busy_r;

  always_comb begin
    case (ph_r)
      msds_pkg::RP_HH: ph_nxt = msds_pkg::RP_LL;
      msds_pkg::RP_LL: ph_nxt = msds_pkg::RP_LH;
      msds_pkg::RP_LH: ph_nxt = msds_pkg::RP_HL;
      msds_pkg::RP_HL: ph_nxt = msds_pkg::RP_HH;
      default:         ph_nxt = msds_pkg::RP_HH;
    endcase
  end

  always_comb begin
    case (ph_r)
      msds_pkg::RP_HH: begin rsel = rhi_r; csel = chi_r; end
      msds_pkg::RP_LL: begin rsel = rlo_r; csel = clo_r; end
      msds_pkg::RP_LH: begin rsel = rlo_r; csel = chi_r; end
      msds_pkg::RP_HL: begin rsel = rhi_r; csel = clo_r; end
      default:         begin rsel = rlo_r; csel = clo_r; end
    endcase
  end

  assign mem_raddr = AW'(AW'(rsel) * AW'(MAX_COLS) + AW'(csel));

  // sign pattern: (+,+) and (-,-) add, cross terms subtract
  assign smp     = msds_pkg::SUM_W'(rd_data);
  assign acc_add = ((tag_ph_r == msds_pkg::RP_HH) || (tag_ph_r == msds_pkg::RP_LL))
                   ? smp : -smp;
  assign acc_sum = (tag_ph_r == msds_pkg::RP_HH) ? acc_add : acc_r + acc_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= msds_pkg::RP_HH;
      tag_v_r     <= 1'b0;
      job_r.valid <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= msds_pkg::RP_HH;
      end else if (busy_r) begin
        busy_r <= (ph_r != msds_pkg::RP_HL);
        ph_r   <= ph_nxt;
      end
      tag_v_r     <= busy_r;
      job_r.valid <= tag_v_r && (tag_ph_r == msds_pkg::RP_HL);
    end
    if (tag_v_r) begin
      job_r.sum     <= acc_sum;
      job_r.bad     <= tag_bad_r;
      job_r.divisor <= msds_pkg::DIVISOR_W'(tag_rspan_r) * msds_pkg::DIVISOR_W'(tag_cspan_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // rejected queries read a harmless corner
      rlo_r   <= bad_now ? '0 : ax_row.lo;
      rhi_r   <= bad_now ? '0 : ax_row.hi;
      clo_r   <= bad_now ? '0 : ax_col.lo;
      chi_r   <= bad_now ? '0 : ax_col.hi;
      rspan_r <= ax_row.span;
      cspan_r <= ax_col.span;
      qbad_r  <= bad_now;
    end
    tag_ph_r    <= ph_r;
    tag_bad_r   <= qbad_r;
    tag_rspan_r <= rspan_r;
    tag_cspan_r <= cspan_r;
    if (tag_v_r) begin
      acc_r <= acc_sum;
    end
  end

endmodule

// ----- rtl/core/msds_div.sv -----
// ----------------------------------------------------------------------------
// msds_div
// Iterative signed divide by span product, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msds_div (
  input  logic           clk,
  input  logic           rst_n,
  input  msds_pkg::job_t job,
  output msds_pkg::res_t res_r
);

  localparam int RW = msds_pkg::DIVISOR_W + 1;

  logic                               busy_r;
  logic [msds_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic                               neg_r, bad_r;
  logic [msds_pkg::DIVISOR_W-1:0]     div_r;
  logic [RW-1:0]                      rem_r, rem_w, trial;
  logic [msds_pkg::DIV_W-1:0]         dq_r, dq_w;
  logic                               last;
  logic signed [msds_pkg::SUM_W-1:0]  sum_abs;
  logic [msds_pkg::MAG_W-1:0]         quo;
  logic [msds_pkg::DERIV_W-1:0]       quo_ext;

  assign sum_abs = job.sum[msds_pkg::SUM_W-1] ? -job.sum : job.sum;
  assign last    = busy_r && (cnt_r == msds_pkg::DIV_CNT_W'(msds_pkg::DIV_STEPS - 1));

  // DIV_BPC restoring steps per cycle
  always_comb begin
    rem_w = rem_r;
    dq_w  = dq_r;
    trial = '0;
    for (int i = 0; i < msds_pkg::DIV_BPC; i++) begin
      trial = {rem_w[msds_pkg::DIVISOR_W-1:0], dq_w[msds_pkg::DIV_W-1]};
      dq_w  = {dq_w[msds_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_w    = trial - {1'b0, div_r};
        dq_w[0]  = 1'b1;
      end else begin
        rem_w = trial;
      end
    end
  end

  assign quo     = dq_w[msds_pkg::MAG_W-1:0];
  assign quo_ext = msds_pkg::DERIV_W'(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      res_r.valid <= 1'b0;
    end else begin
      if (job.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
      res_r.valid <= last;
    end
    if (last) begin
      res_r.bad_query  <= bad_r;
      res_r.derivative <= bad_r ? '0 : (neg_r ? -quo_ext : quo_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid) begin
      neg_r <= job.sum[msds_pkg::SUM_W-1];
      bad_r <= job.bad;
      div_r <= job.divisor;
      rem_r <= '0;
      dq_r  <= msds_pkg::DIV_W'(sum_abs[msds_pkg::MAG_W-1:0]);
    end else if (busy_r) begin
      rem_r <= rem_w;
      dq_r  <= dq_w;
    end
  end

endmodule

// ----- rtl/core/msds_out_fifo.sv -----
// ----------------------------------------------------------------------------
// msds_out_fifo
// Small result queue between the divider and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msds_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msds_pkg::res_t                      res,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msds_pkg::DERIV_W-1:0] out_derivative,
  output logic                                out_bad_query
);

  logic signed [msds_pkg::DERIV_W-1:0] deriv_r [msds_pkg::OUT_DEPTH];
  logic                                bad_r   [msds_pkg::OUT_DEPTH];
  logic [msds_pkg::OUT_PTR_W-1:0]      wp_r, rp_r;
  logic [msds_pkg::OUT_CNT_W-1:0]      cnt_r;
  logic                                pop;

  assign out_valid      = (cnt_r != '0);
  assign pop            = out_valid && !out_stall;
  assign out_derivative = deriv_r[rp_r];
  assign out_bad_query  = bad_r[rp_r];

  // no overflow: entry is credited before a query is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res.valid) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({res.valid, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      deriv_r[wp_r] <= res.derivative;
      bad_r[wp_r]   <= res.bad_query;
    end
  end

endmodule

// ----- rtl/core/mixed_second_derivative_stencil.sv -----
// A query's result passes the four stencil reads, the signed sum, the
// divider and the result queue before it is offered. Queries are paced by
// the four stencil reads on the single frame memory read port.
// Up to 4 queries may be pending on a stalled result channel.
// Reset (rst_n low, synchronous) resets control and config registers; the
// frame memory is not cleared, entries are defined once written.
// ----------------------------------------------------------------------------
// mixed_second_derivative_stencil
// Frame store with d2/dxdy query: four reads, signed sum, divide by spans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mixed_second_derivative_stencil #(
  parameter int MAX_ROWS = msds_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = msds_pkg::DEF_MAX_COLS,
  parameter int MAX_STEP = msds_pkg::DEF_MAX_STEP
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input word channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [msds_pkg::POS_W-1:0]            in_row,
  input  logic [msds_pkg::POS_W-1:0]            in_col,
  input  logic signed [msds_pkg::SAMPLE_W-1:0]  in_sample,
  // result word channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [msds_pkg::DERIV_W-1:0]   out_derivative,
  output logic                                  out_bad_query,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msds_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [msds_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  msds_pkg::cfg_t  cfg_r;
  logic            in_acc, q_acc, out_acc, cfg_acc;
  logic            fetch_hold, cred_full;
  logic [msds_pkg::OUT_CNT_W-1:0] cred_r;

  // frame memory ports
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [msds_pkg::SAMPLE_W-1:0] rd_data;

  msds_pkg::job_t  job;
  msds_pkg::res_t  res;

  // Config is always taken; the user must write it only while idle; the block does not enforce this.
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step <= msds_pkg::STEP_RST;
      cfg_r.rows <= msds_pkg::ROWS_RST;
      cfg_r.cols <= msds_pkg::COLS_RST;
    end else if (cfg_acc) begin
      case (cfg_index)
        msds_pkg::CFG_STEP: cfg_r.step <= cfg_data[msds_pkg::STEP_W-1:0];
        msds_pkg::CFG_ROWS: cfg_r.rows <= cfg_data;
        msds_pkg::CFG_COLS: cfg_r.cols <= cfg_data;
        default: ;  // unknown index dropped
      endcase
    end
  end

  // Input side. A query holds the port until its last read issues; a query
  // is also held back when every result slot is already spoken for, so
  // the read/divide pipe never has to stall.
  assign cred_full = (cred_r == msds_pkg::OUT_CNT_W'(msds_pkg::OUT_DEPTH));
  assign in_stall  = fetch_hold || cred_full;
  assign in_acc    = in_valid && !in_stall;
  assign q_acc     = in_acc && (in_mode == msds_pkg::MODE_QUERY);
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      case ({q_acc, out_acc})
        2'b10:   cred_r <= cred_r + 1'b1;
        2'b01:   cred_r <= cred_r - 1'b1;
        default: cred_r <= cred_r;
      endcase
    end
  end

  // Sample writes go straight to memory; writes beyond the store drop.
  // A write on the edge that issues a query's last read sees read-first
  // ordering, which matches item order.
  assign wr_en   = in_acc && (in_mode == msds_pkg::MODE_WRITE)
                && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign wr_addr = AW'(AW'(in_row) * AW'(MAX_COLS) + AW'(in_col));

  msds_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (in_sample),
    .re      (rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // Query checks, point selection, four reads and the signed sum.
  msds_fetch #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_STEP (MAX_STEP),
    .AW       (AW)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (q_acc),
    .row       (in_row),
    .col       (in_col),
    .rd_data   (rd_data),
    .hold      (fetch_hold),
    .mem_re    (rd_en),
    .mem_raddr (rd_addr),
    .job_r     (job)
  );

  // Divide by span_r * span_c, one job at a time.
  msds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .res_r (res)
  );

  msds_out_fifo u_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_derivative (out_derivative),
    .out_bad_query  (out_bad_query)
  );

endmodule

// ----- rtl/core/msds_checker.sv -----
// ----------------------------------------------------------------------------
// msds_checker
// Port-level checks of the stencil block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msds_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_mode,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [msds_pkg::DERIV_W-1:0] out_derivative,
  input logic                                out_bad_query
);

  logic [3:0] pend_r;
  logic       q_acc, o_acc;

  assign q_acc = in_valid && !in_stall && (in_mode == msds_pkg::MODE_QUERY);
  assign o_acc = out_valid && !out_stall;

  // queries taken minus results delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({q_acc, o_acc})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_derivative)
                               && $stable(out_bad_query))
    else $error("result word changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_query |-> out_derivative == '0)
    else $error("rejected query with nonzero derivative");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending query");

  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'(msds_pkg::OUT_DEPTH))
    else $error("more queries pending than result slots");

endmodule

bind mixed_second_derivative_stencil msds_checker u_msds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_derivative (out_derivative),
  .out_bad_query  (out_bad_query)
);
